// ===== src/swsfr_pkg.sv =====
package swsfr_pkg;

   // Window store geometry
   localparam int WIN_MAX = 16;
   localparam int SLOT_W  = $clog2(WIN_MAX);
   localparam int CNT_W   = $clog2(WIN_MAX + 1);

   // Field widths
   localparam int WLEN_W   = 5;
   localparam int SEQ_W    = 32;
   localparam int HANDLE_W = 16;
   localparam int MODE_W   = 2;
   localparam int DUP_W    = 3;

   // Stream widths, padded to whole bytes
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 120;

   // Event kinds carried on req_tuser
   localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

   localparam logic [SEQ_W-1:0]  SEQ_RESET    = 32'd1;
   localparam logic [WLEN_W-1:0] WLEN_RESET   = 5'd4;
   localparam logic [DUP_W-1:0]  DUP_FAST     = 3'd4;
   localparam logic [DUP_W-1:0]  DUP_ONE      = 3'd1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [HANDLE_W-1:0] payload_handle;
      logic [SEQ_W-1:0]    ack_number;
      logic                ack_checksum_ok;
   } req_item_type;

   // Most significant field first, so accepted lands in bit 0
   typedef struct packed {
      logic                window_full;
      logic [SEQ_W-1:0]    start_seq;
      logic                timer_start;
      logic [SEQ_W-1:0]    stop_seq;
      logic                timer_stop;
      logic [HANDLE_W-1:0] packet_ref;
      logic [SEQ_W-1:0]    packet_seq;
      logic                send_packet;
      logic                accepted;
   } rsp_item_type;

endpackage

// ===== src/sliding_window_sender_fast_retransmit.sv =====
// Cumulative-ACK sliding-window sender with fast retransmit. Each input
// transaction is one event: a send request, an ACK arrival or a timer expiry,
// selected by req_tuser. Every event yields exactly one result transaction
// that says whether a send was taken, which packet (if any) goes out to the
// network, which timer to stop and which to start, and the window-full flag.
// Events are handled one at a time: the capture step takes the event and
// reads the oldest stored payload handle from the window store, whose read
// port is registered; the commit step applies the update and loads the
// result register. A new event is taken while an earlier result still waits
// on rsp_tready, but its update waits until that result has left. The window
// length register may be written only while no event is in progress; values
// of zero act as one and values above sixteen act as sixteen.
module sliding_window_sender_fast_retransmit
   import swsfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Event channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] payload_handle, [47:16] ack_number, [48] ack_checksum_ok
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] mode: send request, ACK arrival or timer expiry
   input  logic [MODE_W-1:0]      req_tuser,
   // Result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] accepted, [1] send_packet, [33:2] packet_seq, [49:34] packet_ref,
   // [50] timer_stop, [82:51] stop_seq, [83] timer_start, [115:84] start_seq,
   // [116] window_full
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Window length register
   input  logic                   csr_wr_en,
   input  logic [WLEN_W-1:0]      csr_wr_data
);

   // Commands from the sequencer to the datapath: capture an event, commit it.
   dp_cmd_type cmd;

   swsfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // The datapath holds the sequence numbers, the duplicate-ACK counter, the
   // window store and the result register.
   swsfr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

// ===== src/swsfr_ctrl.sv =====
module swsfr_ctrl
   import swsfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign cmd.capture = req_tvalid && req_tready;
   assign cmd.commit  = (state_ff == ST_EXEC) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/swsfr_dp.sv =====
module swsfr_dp
   import swsfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   input  logic [MODE_W-1:0]      req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [WLEN_W-1:0]      csr_wr_data
);

   localparam int CMP_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

   // Wraps a slot sum that is known to stay below twice the store depth.
   function automatic logic [SLOT_W-1:0] wrap_slot(input logic [CNT_W:0] sum);
      logic [CNT_W:0] lim;
      lim = (CNT_W + 1)'(WIN_MAX);
      if (sum >= lim) begin
         return SLOT_W'(sum - lim);
      end
      return SLOT_W'(sum);
   endfunction

   logic [HANDLE_W-1:0] store_mem [WIN_MAX];

   logic [WLEN_W-1:0]   window_length_ff;
   logic [SEQ_W-1:0]    base_seq_ff, base_seq_in;
   logic [SEQ_W-1:0]    next_seq_ff, next_seq_in;
   logic [CNT_W-1:0]    in_flight_ff, in_flight_in;
   logic [SLOT_W-1:0]   head_slot_ff, head_slot_in;
   logic [DUP_W-1:0]    dup_count_ff, dup_count_in;
   logic                full_flag_ff, full_flag_in;
   req_item_type        req_ff;
   logic [HANDLE_W-1:0] rd_data_ff;
   rsp_item_type        rsp_ff, rsp_in;

   logic                store_wr;
   logic [SLOT_W-1:0]   wr_slot;
   logic [CMP_W-1:0]    wlen_ext, win_max_c, eff_window;
   logic [SEQ_W-1:0]    ack_off;
   logic [CNT_W-1:0]    ack_off_lo;
   logic                ack_valid;
   logic [DUP_W-1:0]    dup_inc;
   logic [CNT_W-1:0]    left_after;

   assign rsp_tdata = {(RSP_TDATA_W - $bits(rsp_item_type))'(0), rsp_ff};

   assign wlen_ext   = CMP_W'(window_length_ff);
   assign win_max_c  = CMP_W'(WIN_MAX);
   assign eff_window = (wlen_ext == '0) ? CMP_W'(1) :
                       ((wlen_ext > win_max_c) ? win_max_c : wlen_ext);

   assign wr_slot    = wrap_slot((CNT_W + 1)'(head_slot_ff) + (CNT_W + 1)'(in_flight_ff));
   assign ack_off    = req_ff.ack_number - base_seq_ff;
   assign ack_off_lo = ack_off[CNT_W-1:0];
   assign ack_valid  = (in_flight_ff != '0) && req_ff.ack_checksum_ok &&
                       (ack_off[SEQ_W-1:CNT_W] == '0) && (ack_off_lo <= in_flight_ff);
   assign dup_inc    = dup_count_ff + DUP_ONE;
   assign left_after = in_flight_ff - ack_off_lo;

   always_comb begin
      base_seq_in  = base_seq_ff;
      next_seq_in  = next_seq_ff;
      in_flight_in = in_flight_ff;
      head_slot_in = head_slot_ff;
      dup_count_in = dup_count_ff;
      full_flag_in = full_flag_ff;
      store_wr     = 1'b0;
      rsp_in       = '0;

      unique case (req_ff.mode)
         MODE_SEND: begin
            if (CMP_W'(in_flight_ff) < eff_window) begin
               full_flag_in       = 1'b0;
               store_wr           = 1'b1;
               rsp_in.accepted    = 1'b1;
               rsp_in.send_packet = 1'b1;
               rsp_in.packet_seq  = next_seq_ff;
               rsp_in.packet_ref  = req_ff.payload_handle;
               if (in_flight_ff == '0) begin
                  rsp_in.timer_start = 1'b1;
                  rsp_in.start_seq   = next_seq_ff;
               end
               in_flight_in = in_flight_ff + CNT_W'(1);
               next_seq_in  = next_seq_ff + SEQ_W'(1);
            end else begin
               full_flag_in = 1'b1;
            end
         end
         MODE_ACK: begin
            if (ack_valid) begin
               if (ack_off_lo == '0) begin
                  dup_count_in = dup_inc;
                  if (dup_inc == DUP_FAST) begin
                     // Fourth ACK on the same base: fast retransmit
                     rsp_in.timer_stop  = 1'b1;
                     rsp_in.stop_seq    = base_seq_ff;
                     rsp_in.send_packet = 1'b1;
                     rsp_in.packet_seq  = base_seq_ff;
                     rsp_in.packet_ref  = rd_data_ff;
                     rsp_in.timer_start = 1'b1;
                     rsp_in.start_seq   = base_seq_ff;
                     dup_count_in       = '0;
                  end
               end else begin
                  dup_count_in = DUP_ONE;
               end
               if (dup_count_in == DUP_ONE) begin
                  rsp_in.timer_stop = 1'b1;
                  rsp_in.stop_seq   = base_seq_ff;
                  base_seq_in       = req_ff.ack_number;
                  head_slot_in      = wrap_slot((CNT_W + 1)'(head_slot_ff) +
                                                (CNT_W + 1)'(ack_off_lo));
                  in_flight_in      = left_after;
                  if (left_after != '0) begin
                     rsp_in.timer_start = 1'b1;
                     rsp_in.start_seq   = req_ff.ack_number;
                  end
               end
            end
         end
         MODE_TIMEOUT: begin
            if (in_flight_ff != '0) begin
               rsp_in.timer_stop  = 1'b1;
               rsp_in.stop_seq    = base_seq_ff;
               rsp_in.timer_start = 1'b1;
               rsp_in.start_seq   = base_seq_ff;
               rsp_in.send_packet = 1'b1;
               rsp_in.packet_seq  = base_seq_ff;
               rsp_in.packet_ref  = rd_data_ff;
            end
         end
         default: begin
         end
      endcase

      rsp_in.window_full = full_flag_in;
   end

   // Handle store: read the head slot on capture, write on commit of a send
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_data_ff <= store_mem[head_slot_ff];
      end
      if (cmd.commit && store_wr) begin
         store_mem[wr_slot] <= req_ff.payload_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff.mode            <= req_tuser;
         req_ff.payload_handle  <= req_tdata[15:0];
         req_ff.ack_number      <= req_tdata[47:16];
         req_ff.ack_checksum_ok <= req_tdata[48];
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WLEN_RESET;
         base_seq_ff      <= SEQ_RESET;
         next_seq_ff      <= SEQ_RESET;
         in_flight_ff     <= '0;
         head_slot_ff     <= '0;
         dup_count_ff     <= '0;
         full_flag_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_length_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            base_seq_ff  <= base_seq_in;
            next_seq_ff  <= next_seq_in;
            in_flight_ff <= in_flight_in;
            head_slot_ff <= head_slot_in;
            dup_count_ff <= dup_count_in;
            full_flag_ff <= full_flag_in;
         end
      end
   end

endmodule

// ===== src/swsfr_checker.sv =====
module swsfr_checker
   import swsfr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Events are processed one at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second event taken while one is in progress");

   // A taken send never reports a full window.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[116] && rsp_tdata[1])
      else $error("accepted send with full window or no packet");

   // A resend restarts the timer on the resent packet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] && !rsp_tdata[0] |->
         rsp_tdata[50] && rsp_tdata[83] && (rsp_tdata[33:2] == rsp_tdata[115:84]))
      else $error("resend without timer restart on the same packet");

endmodule

bind sliding_window_sender_fast_retransmit swsfr_checker u_swsfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/swsfr_monitor.sv =====
module swsfr_monitor
   import swsfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]      req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [WLEN_W-1:0]      csr_wr_data,
   // Window edges as they stand once the event on the input channel is taken.
   output logic [SEQ_W-1:0]       base_ahead,
   output logic [SEQ_W-1:0]       next_ahead,
   output int unsigned            outstanding,
   output int unsigned            compared,
   output int unsigned            fault_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [WIN_MAX-1:0][HANDLE_W-1:0] store;
      logic [SEQ_W-1:0]                 base;
      logic [SEQ_W-1:0]                 next;
      logic [CNT_W-1:0]                 flight;
      logic [SLOT_W-1:0]                head;
      logic [DUP_W-1:0]                 dups;
      logic                             full;
   } sender_state_type;

   sender_state_type state;
   sender_state_type after;
   rsp_item_type   after_res;
   req_item_type   incoming;
   logic [WLEN_W-1:0] wlen;
   rsp_item_type   outcome_q[$];

   function automatic void sender_step(input sender_state_type cur,
                                       input logic [WLEN_W-1:0] w,
                                       input req_item_type ev, output sender_state_type nxt,
                                       output rsp_item_type res);
      logic [CNT_W-1:0] limit;
      logic [SEQ_W-1:0] ack_off;
      logic [DUP_W-1:0] dups;
      nxt = cur;
      res = '0;
      if (w == '0)
         limit = CNT_W'(1);
      else if (w > WIN_MAX)
         limit = CNT_W'(WIN_MAX);
      else
         limit = CNT_W'(w);
      case (ev.mode)
         MODE_SEND: begin
            if (cur.flight < limit) begin
               nxt.full = 1'b0;
               nxt.store[cur.head + cur.flight[SLOT_W-1:0]] = ev.payload_handle;
               res.accepted    = 1'b1;
               res.send_packet = 1'b1;
               res.packet_seq  = cur.next;
               res.packet_ref  = ev.payload_handle;
               if (cur.flight == '0) begin
                  res.timer_start = 1'b1;
                  res.start_seq   = cur.next;
               end
               nxt.flight = cur.flight + 1'b1;
               nxt.next   = cur.next + 1'b1;
            end else begin
               nxt.full = 1'b1;
            end
         end
         MODE_ACK: begin
            ack_off = ev.ack_number - cur.base;
            if (cur.flight != '0 && ev.ack_checksum_ok && ack_off <= SEQ_W'(cur.flight)) begin
               if (ack_off == '0) begin
                  dups = cur.dups + 1'b1;
                  // The fourth ACK on the base resends the oldest packet.
                  if (dups == DUP_FAST) begin
                     res.timer_stop  = 1'b1;
                     res.stop_seq    = cur.base;
                     res.send_packet = 1'b1;
                     res.packet_seq  = cur.base;
                     res.packet_ref  = cur.store[cur.head];
                     res.timer_start = 1'b1;
                     res.start_seq   = cur.base;
                     dups = '0;
                  end
               end else begin
                  dups = DUP_ONE;
               end
               nxt.dups = dups;
               // A count of one slides the window, possibly by zero.
               if (dups == DUP_ONE) begin
                  res.timer_stop = 1'b1;
                  res.stop_seq   = cur.base;
                  nxt.base   = ev.ack_number;
                  nxt.head   = cur.head + ack_off[SLOT_W-1:0];
                  nxt.flight = cur.flight - ack_off[CNT_W-1:0];
                  if (nxt.flight != '0) begin
                     res.timer_start = 1'b1;
                     res.start_seq   = ev.ack_number;
                  end
               end
            end
         end
         MODE_TIMEOUT: begin
            if (cur.flight != '0) begin
               res.timer_stop  = 1'b1;
               res.stop_seq    = cur.base;
               res.timer_start = 1'b1;
               res.start_seq   = cur.base;
               res.send_packet = 1'b1;
               res.packet_seq  = cur.base;
               res.packet_ref  = cur.store[cur.head];
            end
         end
         default: ;
      endcase
      res.window_full = nxt.full;
   endfunction

   task automatic report_fault(input string msg);
      $display("%s", msg);
      fault_count++;
   endtask

   task automatic compare_field(input string name, input logic [SEQ_W-1:0] got,
                                input logic [SEQ_W-1:0] want);
      if (got !== want)
         report_fault($sformatf("result %0d: %s is 0x%0h, predicted 0x%0h",
                                compared, name, got, want));
   endtask

   always_comb begin
      incoming.mode            = req_tuser;
      incoming.payload_handle  = req_tdata[HANDLE_W-1:0];
      incoming.ack_number      = req_tdata[HANDLE_W +: SEQ_W];
      incoming.ack_checksum_ok = req_tdata[HANDLE_W + SEQ_W];
      after     = state;
      after_res = '0;
      if (req_tvalid && req_tready)
         sender_step(state, wlen, incoming, after, after_res);
   end

   assign base_ahead = after.base;
   assign next_ahead = after.next;

   always @(posedge clock) begin
      sender_state_type fresh;
      rsp_item_type  got;
      rsp_item_type  want;
      if (reset) begin
         fresh      = '0;
         fresh.base = SEQ_RESET;
         fresh.next = SEQ_RESET;
         state       <= fresh;
         wlen        <= WLEN_RESET;
         outcome_q.delete();
         outstanding <= 0;
         compared    = 0;
         fault_count = 0;
      end else begin
         if (csr_wr_en)
            wlen <= csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_item_type)-1:0];
            if (outcome_q.size() == 0) begin
               report_fault($sformatf("result 0x%0h arrived with nothing predicted", rsp_tdata));
            end else begin
               want = outcome_q.pop_front();
               compare_field("accepted",    SEQ_W'(got.accepted),    SEQ_W'(want.accepted));
               compare_field("send_packet", SEQ_W'(got.send_packet), SEQ_W'(want.send_packet));
               compare_field("packet_seq",  got.packet_seq,          want.packet_seq);
               compare_field("packet_ref",  SEQ_W'(got.packet_ref),  SEQ_W'(want.packet_ref));
               compare_field("timer_stop",  SEQ_W'(got.timer_stop),  SEQ_W'(want.timer_stop));
               compare_field("stop_seq",    got.stop_seq,            want.stop_seq);
               compare_field("timer_start", SEQ_W'(got.timer_start), SEQ_W'(want.timer_start));
               compare_field("start_seq",   got.start_seq,           want.start_seq);
               compare_field("window_full", SEQ_W'(got.window_full), SEQ_W'(want.window_full));
               compared++;
            end
         end
         if (req_tvalid && req_tready) begin
            state <= after;
            outcome_q.push_back(after_res);
         end
         outstanding <= outcome_q.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import swsfr_pkg::*;

   // Event kind that the block must ignore.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int unsigned IDLE_PCT      = 14;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned QUIET_LIMIT   = 4000;
   localparam int          PHASES        = 8;

   // Window lengths visited in turn. Zero must act as one, and anything above
   // sixteen as sixteen; 31 and 0 between them exercise every register bit.
   localparam logic [WLEN_W-1:0] WINDOW_PLAN[PHASES] = '{5'd1, 5'd16, 5'd0, 5'd31,
                                                         5'd17, 5'd8, 5'd3, 5'd4};
   localparam int unsigned EVENTS_PLAN[PHASES] = '{100, 130, 100, 100, 100, 100, 100, 100};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [MODE_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en;
   logic [WLEN_W-1:0]      csr_wr_data;

   logic [SEQ_W-1:0]       base_ahead;
   logic [SEQ_W-1:0]       next_ahead;
   int unsigned            outstanding;
   int unsigned            compared;
   int unsigned            fault_count;

   // Randomised idling on each side can be switched off for a clean stretch.
   logic                   gaps_on;
   logic                   stalls_on;
   // Flipping hold_toggle asks the receiver for one long hold-off.
   logic                   hold_toggle;
   logic                   hold_seen;
   int unsigned            hold_left;
   int unsigned            quiet;

   int unsigned            n_send;
   int unsigned            n_ack;
   int unsigned            n_timeout;
   int unsigned            n_unused;
   int unsigned            n_settings;

   sliding_window_sender_fast_retransmit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // The monitor watches both channels and the register port, predicts every
   // result and compares it. It also tells us where the window edges stand,
   // so that ACK numbers can be aimed into the window.
   swsfr_monitor u_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .base_ahead  (base_ahead),
      .next_ahead  (next_ahead),
      .outstanding (outstanding),
      .compared    (compared),
      .fault_count (fault_count)
   );

   always #1 clock = ~clock;

   // Receiver. It normally stalls at random, but on request it holds off for
   // a long stretch, counted here, so that the block fills up behind it.
   always @(posedge clock) begin
      if (reset) begin
         hold_seen  <= 1'b0;
         hold_left  <= 0;
         rsp_tready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(stalls_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   // Watchdog: a run that makes no transaction on either channel for too long
   // has hung, and is failed at once.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, outstanding);
         $display("status: fail");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Offers one event and returns at the clock edge on which it was taken.
   // Valid is only lowered when a gap is actually inserted, so back-to-back
   // events keep it high across the boundary.
   task automatic issue_event(input logic [MODE_W-1:0] kind, input logic [HANDLE_W-1:0] handle,
                              input logic [SEQ_W-1:0] ack, input logic ck_ok);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_TDATA_W'({ck_ok, ack, handle});
      do @(posedge clock); while (!req_tready);
      case (kind)
         MODE_SEND:    n_send++;
         MODE_ACK:     n_ack++;
         MODE_TIMEOUT: n_timeout++;
         default:      n_unused++;
      endcase
   endtask

   // Stops offering and waits until every predicted result has been taken,
   // then lets the block's pipeline drain completely.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The window length may only change while the block is idle.
   task automatic set_window(input logic [WLEN_W-1:0] length);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= length;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      n_settings++;
   endtask

   // Hand-picked opening with a window of two: events on an empty window,
   // the unused kind, a refused send, every kind of ignored ACK, the
   // duplicate count running up to a fast retransmit, a timer expiry, a
   // partial slide and a full acknowledgement that leaves the window empty.
   task automatic directed_checks();
      issue_event(MODE_TIMEOUT, 16'h0000, 32'h0000_0000, 1'b0);
      issue_event(MODE_ACK,     16'h0000, 32'd1,         1'b1);
      issue_event(MODE_UNUSED,  16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      issue_event(MODE_SEND,    16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      issue_event(MODE_SEND,    16'h0000, 32'h0000_0000, 1'b0);
      issue_event(MODE_SEND,    16'hA5A5, 32'h5A5A_5A5A, 1'b0);
      issue_event(MODE_SEND,    16'h1234, 32'h0000_0000, 1'b1);
      issue_event(MODE_ACK,     16'h0000, 32'd2,         1'b0);
      issue_event(MODE_ACK,     16'h0000, 32'd4,         1'b1);
      issue_event(MODE_ACK,     16'h0000, 32'd0,         1'b1);
      issue_event(MODE_ACK,     16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      repeat (4) issue_event(MODE_ACK, 16'h0000, 32'd1, 1'b1);
      issue_event(MODE_TIMEOUT, 16'h0000, 32'h0000_0000, 1'b0);
      issue_event(MODE_ACK,     16'h0000, 32'd2,         1'b1);
      issue_event(MODE_SEND,    16'h5A5A, 32'h0000_0000, 1'b0);
      issue_event(MODE_SEND,    16'h0F0F, 32'h0000_0000, 1'b0);
      issue_event(MODE_ACK,     16'h0000, 32'd4,         1'b1);
      issue_event(MODE_TIMEOUT, 16'h0000, 32'h0000_0000, 1'b1);
      issue_event(MODE_ACK,     16'h0000, 32'd4,         1'b1);
   endtask

   // Mostly well-formed traffic: sends, ACKs aimed inside the window, runs of
   // duplicate ACKs on the base and timer expiries. A small share is noise
   // (stray ACK numbers, ACKs just outside the window, the unused kind),
   // which does not count towards the requested number of events.
   task automatic random_traffic(input int unsigned count);
      int unsigned done_n;
      int unsigned pick;
      int unsigned span;
      int unsigned burst;
      done_n = 0;
      while (done_n < count) begin
         pick = $urandom_range(99);
         span = next_ahead - base_ahead;
         if (pick < 45) begin
            issue_event(MODE_SEND, 16'($urandom), 32'($urandom), 1'($urandom));
            done_n++;
         end else if (pick < 77) begin
            issue_event(MODE_ACK, 16'($urandom), base_ahead + $urandom_range(span),
                        $urandom_range(99) >= 8);
            done_n++;
         end else if (pick < 85) begin
            burst = $urandom_range(6, 3);
            repeat (burst) issue_event(MODE_ACK, 16'($urandom), base_ahead, 1'b1);
            done_n += burst;
         end else if (pick < 93) begin
            issue_event(MODE_TIMEOUT, 16'($urandom), 32'($urandom), 1'($urandom));
            done_n++;
         end else begin
            case ($urandom_range(3))
               0: issue_event(MODE_ACK, 16'($urandom), 32'($urandom), 1'($urandom));
               1: issue_event(MODE_ACK, 16'($urandom), base_ahead - 1'b1, 1'b1);
               2: issue_event(MODE_ACK, 16'($urandom), next_ahead + 1'b1, 1'b1);
               default: issue_event(MODE_UNUSED, 16'($urandom), 32'($urandom), 1'($urandom));
            endcase
         end
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= MODE_SEND;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      gaps_on     <= 1'b1;
      stalls_on   <= 1'b1;
      hold_toggle <= 1'b0;
      n_send      = 0;
      n_ack       = 0;
      n_timeout   = 0;
      n_unused    = 0;
      n_settings  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_window(5'd2);
      directed_checks();

      for (int i = 0; i < PHASES; i++) begin
         // Phase three runs with both sides flat out, with no idling at all.
         gaps_on   <= (i != 3);
         stalls_on <= (i != 3);
         set_window(WINDOW_PLAN[i]);
         // With the widest window, the receiver holds off while sends keep
         // coming, so results back up and the input channel has to stall.
         if (i == 1)
            hold_toggle <= ~hold_toggle;
         random_traffic(EVENTS_PLAN[i]);
      end

      settle();
      $display("Covered %0d sends, %0d ACKs, %0d timer expiries and %0d unused events",
               n_send, n_ack, n_timeout, n_unused);
      $display("over %0d window lengths; %0d results compared, %0d mismatches.",
               n_settings, compared, fault_count);
      if (fault_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
